>>> rtl/cqst_pkg.sv
// cqst_pkg: types, codes and constants of the query session table
// used by the interfaces, the controller, the datapath and the top level
package cqst_pkg;

	// field widths
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned SLOT_W    = 6;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned LEN_W     = 13;
	localparam int unsigned TYPE_W    = 8;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned SEND_W    = 2;
	localparam int unsigned PHASE_W   = 3;
	localparam int unsigned ATTEMPT_W = 4;
	localparam int unsigned LIVE_W    = 7;
	localparam int unsigned TMO_W     = 16;
	localparam int unsigned CFG_IDX_W = 4;
	localparam int unsigned CFG_DAT_W = 16;

	// item modes
	localparam logic [MODE_W-1:0] MODE_ARM    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POLL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PACKET = 2'd2;

	// request codes
	localparam logic [SEND_W-1:0] SEND_NONE      = 2'd0;
	localparam logic [SEND_W-1:0] SEND_CHALLENGE = 2'd1;
	localparam logic [SEND_W-1:0] SEND_PLAYERS   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REPLY_TIMEOUT = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS  = 4'd1;

	localparam logic [TMO_W-1:0]     TIMEOUT_RESET  = 16'd1000;
	localparam logic [ATTEMPT_W-1:0] ATTEMPTS_RESET = 4'd3;
	localparam logic [ATTEMPT_W-1:0] ATTEMPT_MAX    = 4'd15;

	// packet classification
	localparam logic [TYPE_W-1:0] TYPE_CHALLENGE    = 8'h41;
	localparam logic [TYPE_W-1:0] TYPE_PLAYERS      = 8'h44;
	localparam logic [LEN_W-1:0]  MIN_CHALLENGE_LEN = 13'd9;
	localparam logic [LEN_W-1:0]  MIN_PLAYERS_LEN   = 13'd6;
	localparam logic [LEN_W-1:0]  MIN_HEADER_LEN    = 13'd4;

	typedef enum logic [PHASE_W-1:0] {
		PH_NOT_STARTED    = 3'd0,
		PH_WAIT_CHALLENGE = 3'd1,
		PH_GOT_CHALLENGE  = 3'd2,
		PH_WAIT_PLAYERS   = 3'd3,
		PH_DONE           = 3'd4
	} phase_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ctl_state_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [SLOT_W-1:0] slot;
		logic [TIME_W-1:0] now_ms;
		logic [LEN_W-1:0]  packet_length;
		logic [TYPE_W-1:0] type_byte;
		logic [WORD_W-1:0] challenge_word;
	} item_t;

	typedef struct packed {
		logic [SEND_W-1:0]  send_request;
		logic [WORD_W-1:0]  request_challenge;
		logic [PHASE_W-1:0] slot_phase;
		logic               slot_success;
		logic               slot_failed;
		logic               hand_to_parser;
		logic [LIVE_W-1:0]  running_sessions;
	} result_t;

	// one session table entry
	typedef struct packed {
		phase_t                phase;
		logic [WORD_W-1:0]    challenge;
		logic [TIME_W-1:0]    last_time;
		logic [ATTEMPT_W-1:0] attempts;
		logic                 success;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{
		phase:     PH_DONE,
		challenge: '0,
		last_time: '0,
		attempts:  '0,
		success:   1'b0
	};

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_hold;
	} dp_stat_t;

endpackage

>>> rtl/cqst_item_if.sv
// cqst_item_if: input item channel with valid/ready handshake
// depends on cqst_pkg for field widths
interface cqst_item_if import cqst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [SLOT_W-1:0] slot;
	logic [TIME_W-1:0] now_ms;
	logic [LEN_W-1:0]  packet_length;
	logic [TYPE_W-1:0] type_byte;
	logic [WORD_W-1:0] challenge_word;

	modport source (output valid, mode, slot, now_ms, packet_length, type_byte,
		challenge_word, input ready);
	modport sink (input valid, mode, slot, now_ms, packet_length, type_byte,
		challenge_word, output ready);
endinterface

>>> rtl/cqst_result_if.sv
// cqst_result_if: result channel with valid/ready handshake
// depends on cqst_pkg for field widths
interface cqst_result_if import cqst_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [SEND_W-1:0]  send_request;
	logic [WORD_W-1:0]  request_challenge;
	logic [PHASE_W-1:0] slot_phase;
	logic               slot_success;
	logic               slot_failed;
	logic               hand_to_parser;
	logic [LIVE_W-1:0]  running_sessions;

	modport source (output valid, send_request, request_challenge, slot_phase,
		slot_success, slot_failed, hand_to_parser, running_sessions, input ready);
	modport sink (input valid, send_request, request_challenge, slot_phase,
		slot_success, slot_failed, hand_to_parser, running_sessions, output ready);
endinterface

>>> rtl/cqst_cfg_if.sv
// cqst_cfg_if: register write channel, index and data with valid/ready
// depends on cqst_pkg for field widths
interface cqst_cfg_if import cqst_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/cqst_ctrl.sv
// cqst_ctrl: two-state controller, read of the session entry then commit
// depends on cqst_pkg
module cqst_ctrl import cqst_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (!stat.out_hold) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.commit = !stat.out_hold;
			end
			default: ;
		endcase
	end

endmodule

>>> rtl/cqst_dp.sv
// cqst_dp: session memory, entry update logic, config registers,
// live count and result register; depends on cqst_pkg
module cqst_dp import cqst_pkg::*; #(
	parameter int unsigned SESSION_SLOTS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	input  item_t                item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output result_t              res
);

	// only slots reachable by the slot field are stored
	localparam int unsigned SLOT_SPAN = 1 << SLOT_W;
	localparam int unsigned DEPTH = (SESSION_SLOTS < SLOT_SPAN) ? SESSION_SLOTS : SLOT_SPAN;
	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	entry_t               mem_q [DEPTH];
	logic [DEPTH-1:0]     vld_q;
	entry_t               rd_data_s1;
	logic                 rd_vld_s1;
	item_t                item_q;
	logic                 in_range_q;
	logic [IDX_W-1:0]     idx_q;
	logic [TMO_W-1:0]     timeout_q;
	logic [ATTEMPT_W-1:0] max_att_q;
	logic [LIVE_W-1:0]    live_q;
	logic                 out_valid_q;
	result_t              res_q;

	logic [IDX_W-1:0]     rd_idx;
	logic                 in_range;
	entry_t               cur;
	entry_t               nxt;
	logic [TIME_W-1:0]    elapsed;
	logic                 timed_out;
	logic [ATTEMPT_W-1:0] att_inc;
	logic                 do_fail;
	logic                 do_succ;
	phase_t               retry_ph;
	logic                 live_inc;
	logic                 live_dec;
	logic [LIVE_W-1:0]    live_d;
	result_t              res_d;

	assign rd_idx   = item.slot[IDX_W-1:0];
	assign in_range = (32'(item.slot) < SESSION_SLOTS);

	// registered read of the addressed entry
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_data_s1 <= mem_q[rd_idx];
			item_q     <= item;
			idx_q      <= rd_idx;
			in_range_q <= in_range;
		end
		if (cmd.commit && in_range_q) begin
			mem_q[idx_q] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cmd.capture) rd_vld_s1 <= vld_q[rd_idx];
			if (cmd.commit && in_range_q) vld_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			max_att_q <= ATTEMPTS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_REPLY_TIMEOUT: timeout_q <= cfg_data;
				REG_MAX_ATTEMPTS:  max_att_q <= cfg_data[ATTEMPT_W-1:0];
				default: ;
			endcase
		end
	end

	// entry update
	always_comb begin
		cur       = rd_vld_s1 ? rd_data_s1 : ENTRY_RESET;
		nxt       = cur;
		elapsed   = item_q.now_ms - cur.last_time;
		timed_out = elapsed > {{(TIME_W-TMO_W){1'b0}}, timeout_q};
		att_inc   = (cur.attempts == ATTEMPT_MAX) ? ATTEMPT_MAX : cur.attempts + 4'd1;
		do_fail   = 1'b0;
		do_succ   = 1'b0;
		retry_ph  = PH_NOT_STARTED;
		live_inc  = 1'b0;
		live_dec  = 1'b0;
		res_d     = '0;
		res_d.send_request = SEND_NONE;

		unique case (item_q.mode)
			MODE_ARM: begin
				live_inc = (cur.phase == PH_DONE);
				nxt = '{phase: PH_NOT_STARTED, challenge: '0, last_time: '0,
					attempts: '0, success: 1'b0};
			end
			MODE_POLL: begin
				case (cur.phase)
					PH_NOT_STARTED: begin
						res_d.send_request = SEND_CHALLENGE;
						nxt.phase          = PH_WAIT_CHALLENGE;
						nxt.last_time      = item_q.now_ms;
					end
					PH_GOT_CHALLENGE: begin
						res_d.send_request      = SEND_PLAYERS;
						res_d.request_challenge = cur.challenge;
						nxt.phase               = PH_WAIT_PLAYERS;
						nxt.last_time           = item_q.now_ms;
					end
					PH_WAIT_CHALLENGE, PH_WAIT_PLAYERS: begin
						do_fail  = timed_out;
						retry_ph = (cur.phase == PH_WAIT_CHALLENGE) ?
							PH_NOT_STARTED : PH_GOT_CHALLENGE;
					end
					default: ;
				endcase
			end
			MODE_PACKET: begin
				case (cur.phase)
					PH_WAIT_CHALLENGE: begin
						if (item_q.packet_length < MIN_CHALLENGE_LEN ||
							item_q.type_byte != TYPE_CHALLENGE) begin
							// player list straight away, no challenge needed
							if (item_q.packet_length > MIN_HEADER_LEN &&
								item_q.type_byte == TYPE_PLAYERS) begin
								do_succ = 1'b1;
							end else begin
								do_fail  = 1'b1;
								retry_ph = PH_NOT_STARTED;
							end
						end else begin
							nxt.challenge = item_q.challenge_word;
							nxt.phase     = PH_GOT_CHALLENGE;
							nxt.attempts  = '0;
						end
					end
					PH_WAIT_PLAYERS: begin
						if (item_q.packet_length < MIN_PLAYERS_LEN ||
							item_q.type_byte != TYPE_PLAYERS) begin
							do_fail  = 1'b1;
							retry_ph = PH_GOT_CHALLENGE;
						end else begin
							do_succ = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		if (do_fail) begin
			nxt.attempts = att_inc;
			if (att_inc >= max_att_q) begin
				nxt.phase          = PH_DONE;
				live_dec           = 1'b1;
				res_d.slot_failed  = 1'b1;
			end else begin
				nxt.phase = retry_ph;
			end
		end
		if (do_succ) begin
			nxt.phase            = PH_DONE;
			nxt.success          = 1'b1;
			live_dec             = 1'b1;
			res_d.hand_to_parser = 1'b1;
		end

		// out-of-range slot leaves everything alone
		if (!in_range_q) begin
			live_inc = 1'b0;
			live_dec = 1'b0;
			res_d    = '0;
			res_d.send_request = SEND_NONE;
		end

		live_d = live_q;
		if (live_inc) begin
			live_d = live_q + 7'd1;
		end else if (live_dec && live_q != '0) begin
			live_d = live_q - 7'd1;
		end

		res_d.slot_phase       = in_range_q ? nxt.phase : PH_DONE;
		res_d.slot_success     = in_range_q & nxt.success;
		res_d.running_sessions = live_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				live_q      <= live_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) res_q <= res_d;
	end

	assign stat.out_hold = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign res           = res_q;

endmodule

>>> rtl/challenge_query_session_table_core.sv
// challenge_query_session_table_core: query session table, top level
// entry read into a register when the item is taken, updated with the result on commit
// one item at a time, set by the read-modify-write on the session memory
// a full result register stalls the update state until the result transaction completes
// reset: async active low; all sessions read as done through per-entry valid bits,
// live count zero, timeout 1000 ms, max attempts 3; no clearing pass needed
module challenge_query_session_table_core import cqst_pkg::*; #(
	parameter int unsigned SESSION_SLOTS = 64
) (
	input logic            clk,
	input logic            arst_n,
	cqst_item_if.sink      item_in,
	cqst_result_if.source  result_out,
	cqst_cfg_if.sink       cfg
);

	dp_cmd_t  cmd;
	dp_stat_t stat;
	item_t    item;
	result_t  res;
	logic     in_ready;
	logic     out_valid;

	// payload fields gathered into one item word
	assign item = '{
		mode:           item_in.mode,
		slot:           item_in.slot,
		now_ms:         item_in.now_ms,
		packet_length:  item_in.packet_length,
		type_byte:      item_in.type_byte,
		challenge_word: item_in.challenge_word
	};

	assign item_in.ready = in_ready;

	// register writes are taken every cycle
	assign cfg.ready = 1'b1;

	// controller: idle / execute sequencing of one item
	cqst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: session memory, update logic and result register
	cqst_dp #(
		.SESSION_SLOTS (SESSION_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item      (item),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.out_valid (out_valid),
		.out_ready (result_out.ready),
		.res       (res)
	);

	// result transaction
	assign result_out.valid             = out_valid;
	assign result_out.send_request      = res.send_request;
	assign result_out.request_challenge = res.request_challenge;
	assign result_out.slot_phase        = res.slot_phase;
	assign result_out.slot_success      = res.slot_success;
	assign result_out.slot_failed       = res.slot_failed;
	assign result_out.hand_to_parser    = res.hand_to_parser;
	assign result_out.running_sessions  = res.running_sessions;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// testbench for challenge_query_session_table_core: directed table, then random sessions
// depends on cqst_pkg and the item, result and register interfaces
module testbench;
	import cqst_pkg::*;

	localparam int SLOTS       = 1 << SLOT_W;
	localparam int DIR_ROWS    = 27;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 215;
	localparam int CYCLE_LIMIT = 400000;

	// mode value the block leaves alone
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SEND,
		IDLE_RECV,
		IDLE_BOTH
	} idle_mode_t;

	// one row of the directed table: the item, and a hand-written result where typed is set
	typedef struct packed {
		item_t   stim;
		logic    typed;
		result_t want;
	} dir_row_t;

	localparam result_t NO_RESULT = '0;

	// register settings and handshake pressure per random phase
	localparam logic [TMO_W-1:0] PHASE_TMO [PHASES] =
		'{16'd1000, 16'd1, 16'd65535, 16'd20, 16'd300, 16'd5};
	localparam logic [ATTEMPT_W-1:0] PHASE_TRIES [PHASES] =
		'{4'd3, 4'd1, 4'd15, 4'd0, 4'd2, 4'd8};
	localparam idle_mode_t PHASE_IDLE [PHASES] =
		'{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_BOTH};

	logic clk;
	logic arst_n;

	cqst_item_if   item_bus ();
	cqst_result_if result_bus ();
	cqst_cfg_if    cfg_bus ();

	challenge_query_session_table_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_bus),
		.result_out (result_bus),
		.cfg        (cfg_bus)
	);

	// session table as the testbench believes it to be
	phase_t               sess_phase     [SLOTS];
	logic [WORD_W-1:0]    sess_challenge [SLOTS];
	logic [TIME_W-1:0]    sess_time      [SLOTS];
	logic [ATTEMPT_W-1:0] sess_tries     [SLOTS];
	logic                 sess_ok        [SLOTS];
	logic [LIVE_W-1:0]    live_sessions;
	logic [TMO_W-1:0]     reply_tmo;
	logic [ATTEMPT_W-1:0] max_tries;

	result_t pending_results [$];
	result_t seen_result;
	result_t due_result;
	int      mismatch_count;
	int      cycle_count;
	int      send_idle_pct;
	int      stall_pct;

	// directed walk at reset settings: timeout 1000 ms, three attempts
	dir_row_t directed_rows [DIR_ROWS] = '{
		// poll, odd packet and unused mode on done slots after reset
		'{'{MODE_POLL, 6'd0, 32'h0, 13'd0, 8'h00, 32'h0}, 1'b1,
			'{SEND_NONE, 32'h0, PH_DONE, 1'b0, 1'b0, 1'b0, 7'd0}},
		'{'{MODE_PACKET, 6'd63, 32'hffff_ffff, 13'd4096, 8'hff, 32'hffff_ffff}, 1'b1,
			'{SEND_NONE, 32'h0, PH_DONE, 1'b0, 1'b0, 1'b0, 7'd0}},
		'{'{MODE_UNUSED, 6'd5, 32'hffff_ffff, 13'd4096, 8'hff, 32'hffff_ffff}, 1'b1,
			'{SEND_NONE, 32'h0, PH_DONE, 1'b0, 1'b0, 1'b0, 7'd0}},
		// arm both end slots
		'{'{MODE_ARM, 6'd0, 32'h0, 13'd0, 8'h00, 32'h0}, 1'b1,
			'{SEND_NONE, 32'h0, PH_NOT_STARTED, 1'b0, 1'b0, 1'b0, 7'd1}},
		'{'{MODE_ARM, 6'd63, 32'h0, 13'd0, 8'h00, 32'h0}, 1'b1,
			'{SEND_NONE, 32'h0, PH_NOT_STARTED, 1'b0, 1'b0, 1'b0, 7'd2}},
		// packet before any request goes nowhere
		'{'{MODE_PACKET, 6'd0, 32'h0, 13'd9, 8'h41, 32'h1}, 1'b0, NO_RESULT},
		// challenge request at the top of the time range, then the timeout edge across the wrap
		'{'{MODE_POLL, 6'd0, 32'hffff_ffff, 13'd0, 8'h00, 32'h0}, 1'b1,
			'{SEND_CHALLENGE, 32'h0, PH_WAIT_CHALLENGE, 1'b0, 1'b0, 1'b0, 7'd2}},
		'{'{MODE_POLL, 6'd0, 32'h0000_03e7, 13'd0, 8'h00, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_POLL, 6'd0, 32'h0000_03e8, 13'd0, 8'h00, 32'h0}, 1'b1,
			'{SEND_NONE, 32'h0, PH_NOT_STARTED, 1'b0, 1'b0, 1'b0, 7'd2}},
		// short challenge reply, then a good one
		'{'{MODE_POLL, 6'd0, 32'h1234_5678, 13'd0, 8'h00, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_PACKET, 6'd0, 32'h0, 13'd8, 8'h41, 32'h5555_aaaa}, 1'b0, NO_RESULT},
		'{'{MODE_POLL, 6'd0, 32'h0, 13'd0, 8'h00, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_PACKET, 6'd0, 32'h0, 13'd9, 8'h41, 32'hdead_beef}, 1'b0, NO_RESULT},
		// player request, short list, retry, good list
		'{'{MODE_POLL, 6'd0, 32'h0, 13'd0, 8'h00, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_PACKET, 6'd0, 32'h0, 13'd5, 8'h44, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_POLL, 6'd0, 32'h5, 13'd0, 8'h00, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_PACKET, 6'd0, 32'h0, 13'd6, 8'h44, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_POLL, 6'd0, 32'h0, 13'd0, 8'h00, 32'h0}, 1'b0, NO_RESULT},
		// player list arriving instead of a challenge
		'{'{MODE_POLL, 6'd63, 32'h0, 13'd0, 8'h00, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_PACKET, 6'd63, 32'h0, 13'd5, 8'h44, 32'h0}, 1'b0, NO_RESULT},
		// rearm and run out of attempts
		'{'{MODE_ARM, 6'd63, 32'h0, 13'd0, 8'h00, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_POLL, 6'd63, 32'h0, 13'd0, 8'h00, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_PACKET, 6'd63, 32'h0, 13'd4, 8'h44, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_POLL, 6'd63, 32'd100, 13'd0, 8'h00, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_PACKET, 6'd63, 32'h0, 13'd4096, 8'h00, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_POLL, 6'd63, 32'h0, 13'd0, 8'h00, 32'h0}, 1'b0, NO_RESULT},
		'{'{MODE_POLL, 6'd63, 32'd1001, 13'd0, 8'h00, 32'h0}, 1'b1,
			'{SEND_NONE, 32'h0, PH_DONE, 1'b0, 1'b1, 1'b0, 7'd0}}
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// one failed attempt: fall back to the retry phase or end the session
	function automatic logic count_failure(input logic [SLOT_W-1:0] s, input phase_t retry);
		if (sess_tries[s] != ATTEMPT_MAX)
			sess_tries[s] = sess_tries[s] + 1'b1;
		sess_phase[s] = retry;
		if (sess_tries[s] >= max_tries) begin
			sess_phase[s] = PH_DONE;
			if (live_sessions != 0)
				live_sessions = live_sessions - 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void close_with_list(input logic [SLOT_W-1:0] s);
		sess_phase[s] = PH_DONE;
		sess_ok[s]    = 1'b1;
		if (live_sessions != 0)
			live_sessions = live_sessions - 1'b1;
	endfunction

	// advance the session table by one item and return the result it should give
	function automatic result_t apply_session_item(input item_t it);
		result_t          r;
		logic [SLOT_W-1:0] s;
		phase_t           ph;
		logic [TIME_W-1:0] elapsed;
		r       = '0;
		s       = it.slot;
		ph      = sess_phase[s];
		elapsed = it.now_ms - sess_time[s];
		case (it.mode)
			MODE_ARM: begin
				if (ph == PH_DONE)
					live_sessions = live_sessions + 1'b1;
				sess_phase[s]     = PH_NOT_STARTED;
				sess_tries[s]     = '0;
				sess_ok[s]        = 1'b0;
				sess_challenge[s] = '0;
				sess_time[s]      = '0;
			end
			MODE_POLL: begin
				if (ph == PH_NOT_STARTED) begin
					r.send_request = SEND_CHALLENGE;
					sess_phase[s]  = PH_WAIT_CHALLENGE;
					sess_time[s]   = it.now_ms;
				end else if (ph == PH_GOT_CHALLENGE) begin
					r.send_request      = SEND_PLAYERS;
					r.request_challenge = sess_challenge[s];
					sess_phase[s]       = PH_WAIT_PLAYERS;
					sess_time[s]        = it.now_ms;
				end else if (ph == PH_WAIT_CHALLENGE || ph == PH_WAIT_PLAYERS) begin
					if (elapsed > TIME_W'(reply_tmo))
						r.slot_failed = count_failure(s,
							(ph == PH_WAIT_CHALLENGE) ? PH_NOT_STARTED : PH_GOT_CHALLENGE);
				end
			end
			MODE_PACKET: begin
				if (ph == PH_WAIT_CHALLENGE) begin
					if (it.packet_length >= MIN_CHALLENGE_LEN && it.type_byte == TYPE_CHALLENGE) begin
						sess_challenge[s] = it.challenge_word;
						sess_phase[s]     = PH_GOT_CHALLENGE;
						sess_tries[s]     = '0;
					end else if (it.packet_length > MIN_HEADER_LEN && it.type_byte == TYPE_PLAYERS) begin
						close_with_list(s);
						r.hand_to_parser = 1'b1;
					end else begin
						r.slot_failed = count_failure(s, PH_NOT_STARTED);
					end
				end else if (ph == PH_WAIT_PLAYERS) begin
					if (it.packet_length >= MIN_PLAYERS_LEN && it.type_byte == TYPE_PLAYERS) begin
						close_with_list(s);
						r.hand_to_parser = 1'b1;
					end else begin
						r.slot_failed = count_failure(s, PH_GOT_CHALLENGE);
					end
				end
			end
			default: ;
		endcase
		r.slot_phase       = sess_phase[s];
		r.slot_success     = sess_ok[s];
		r.running_sessions = live_sessions;
		return r;
	endfunction

	// mostly well-formed session traffic on a few hot slots, with some noise mixed in
	function automatic item_t random_session_item();
		item_t            it;
		logic [SLOT_W-1:0] s;
		int unsigned      pick;
		it.mode           = MODE_ARM;
		it.slot           = '0;
		it.now_ms         = $urandom;
		it.packet_length  = LEN_W'($urandom_range(4096, 0));
		it.type_byte      = TYPE_W'($urandom_range(255, 0));
		it.challenge_word = $urandom;
		if ($urandom_range(99, 0) < 80)
			s = SLOT_W'($urandom_range(7, 0));
		else
			s = SLOT_W'($urandom_range(SLOTS - 1, 0));
		it.slot = s;
		pick    = $urandom_range(99, 0);
		// noise: anything at all, unused mode included
		if (pick < 8) begin
			it.mode = MODE_W'($urandom_range(3, 0));
			return it;
		end
		pick = $urandom_range(99, 0);
		case (sess_phase[s])
			PH_DONE: begin
				if (pick < 70)      it.mode = MODE_ARM;
				else if (pick < 85) it.mode = MODE_POLL;
				else                it.mode = MODE_PACKET;
			end
			PH_NOT_STARTED: begin
				if (pick < 85)      it.mode = MODE_POLL;
				else if (pick < 95) it.mode = MODE_PACKET;
				else                it.mode = MODE_ARM;
			end
			PH_GOT_CHALLENGE: begin
				it.mode = (pick < 90) ? MODE_POLL : MODE_PACKET;
			end
			default: begin
				// waiting for a reply
				if (pick < 45) begin
					it.mode = MODE_PACKET;
					if (sess_phase[s] == PH_WAIT_CHALLENGE) begin
						it.type_byte     = TYPE_CHALLENGE;
						it.packet_length = ($urandom_range(3, 0) == 0) ? MIN_CHALLENGE_LEN :
							LEN_W'($urandom_range(4096, 9));
					end else begin
						it.type_byte     = TYPE_PLAYERS;
						it.packet_length = ($urandom_range(3, 0) == 0) ? MIN_PLAYERS_LEN :
							LEN_W'($urandom_range(4096, 6));
					end
				end else if (pick < 55) begin
					// player list, early when still waiting for a challenge
					it.mode          = MODE_PACKET;
					it.type_byte     = TYPE_PLAYERS;
					it.packet_length = LEN_W'($urandom_range(4096, 5));
				end else if (pick < 70) begin
					// bad or short reply
					it.mode = MODE_PACKET;
					case ($urandom_range(2, 0))
						0: begin
							it.type_byte     = TYPE_CHALLENGE;
							it.packet_length = LEN_W'($urandom_range(8, 0));
						end
						1: begin
							it.type_byte     = TYPE_PLAYERS;
							it.packet_length = LEN_W'($urandom_range(5, 0));
						end
						default: ;
					endcase
				end else if (pick < 85) begin
					// poll past the reply window
					it.mode   = MODE_POLL;
					it.now_ms = sess_time[s] + TIME_W'(reply_tmo) + TIME_W'($urandom_range(3, 1));
				end else begin
					// poll inside the reply window, the edge included
					it.mode   = MODE_POLL;
					it.now_ms = sess_time[s] + TIME_W'($urandom_range(reply_tmo, 0));
				end
			end
		endcase
		return it;
	endfunction

	function automatic string show_result(input result_t r);
		return $sformatf("req=%0d chal=%h phase=%0d ok=%0b failed=%0b parse=%0b live=%0d",
			r.send_request, r.request_challenge, r.slot_phase, r.slot_success,
			r.slot_failed, r.hand_to_parser, r.running_sessions);
	endfunction

	// present one item, wait for its transaction, queue what it should produce
	task automatic drive_item(input item_t it, input logic typed, input result_t typed_want);
		result_t want;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid          <= 1'b1;
		item_bus.mode           <= it.mode;
		item_bus.slot           <= it.slot;
		item_bus.now_ms         <= it.now_ms;
		item_bus.packet_length  <= it.packet_length;
		item_bus.type_byte      <= it.type_byte;
		item_bus.challenge_word <= it.challenge_word;
		do @(posedge clk); while (!item_bus.ready);
		want = apply_session_item(it);
		if (typed)
			want = typed_want;
		pending_results = {pending_results, want};
	endtask

	// both registers, back to back, while the block is idle
	task automatic write_settings(input logic [TMO_W-1:0] tmo, input logic [ATTEMPT_W-1:0] tries);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= REG_REPLY_TIMEOUT;
		cfg_bus.data  <= CFG_DAT_W'(tmo);
		do @(posedge clk); while (!cfg_bus.ready);
		reply_tmo     = tmo;
		cfg_bus.index <= REG_MAX_ATTEMPTS;
		cfg_bus.data  <= CFG_DAT_W'(tries);
		do @(posedge clk); while (!cfg_bus.ready);
		max_tries     = tries;
		cfg_bus.valid <= 1'b0;
	endtask

	// receiver side: random stalls at the phase's rate
	always @(posedge clk)
		result_bus.ready <= ($urandom_range(99, 0) >= stall_pct);

	// compare every result transaction with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			seen_result = '{result_bus.send_request, result_bus.request_challenge,
				result_bus.slot_phase, result_bus.slot_success, result_bus.slot_failed,
				result_bus.hand_to_parser, result_bus.running_sessions};
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: %s", show_result(seen_result));
			end else begin
				due_result = pending_results.pop_front();
				if (seen_result !== due_result) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected %s, got %s",
							show_result(due_result), show_result(seen_result));
				end
			end
		end
	end

	// watchdog on a hung handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		item_t rnd_item;
		int    ph_idx;
		int    n;

		// every input known from time zero
		arst_n                  = 1'b0;
		item_bus.valid          = 1'b0;
		item_bus.mode           = MODE_ARM;
		item_bus.slot           = '0;
		item_bus.now_ms         = '0;
		item_bus.packet_length  = '0;
		item_bus.type_byte      = '0;
		item_bus.challenge_word = '0;
		result_bus.ready        = 1'b0;
		cfg_bus.valid           = 1'b0;
		cfg_bus.index           = REG_REPLY_TIMEOUT;
		cfg_bus.data            = '0;
		mismatch_count          = 0;
		cycle_count             = 0;
		send_idle_pct           = 0;
		stall_pct               = 0;

		// table after reset: every session done
		for (int i = 0; i < SLOTS; i++) begin
			sess_phase[i]     = PH_DONE;
			sess_challenge[i] = '0;
			sess_time[i]      = '0;
			sess_tries[i]     = '0;
			sess_ok[i]        = 1'b0;
		end
		live_sessions = '0;
		reply_tmo     = TIMEOUT_RESET;
		max_tries     = ATTEMPTS_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed walk, no idling
		for (int i = 0; i < DIR_ROWS; i++)
			drive_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
		item_bus.valid <= 1'b0;

		// random phases, each with its own register settings and pressure
		for (ph_idx = 0; ph_idx < PHASES; ph_idx++) begin
			while (pending_results.size() != 0)
				@(posedge clk);
			repeat (4) @(posedge clk);
			write_settings(PHASE_TMO[ph_idx], PHASE_TRIES[ph_idx]);
			case (PHASE_IDLE[ph_idx])
				IDLE_SEND: begin send_idle_pct = 57; stall_pct = 0;  end
				IDLE_RECV: begin send_idle_pct = 0;  stall_pct = 57; end
				IDLE_BOTH: begin send_idle_pct = 11; stall_pct = 11; end
				default:   begin send_idle_pct = 0;  stall_pct = 0;  end
			endcase
			for (n = 0; n < PHASE_ITEMS; n++) begin
				rnd_item = random_session_item();
				drive_item(rnd_item, 1'b0, NO_RESULT);
			end
			item_bus.valid <= 1'b0;
		end

		// drain, then watch for anything stray
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
